// ----- rtl/pes_pkg.sv -----
`timescale 1ns / 1ps

package pes_pkg;

  localparam int COORD_BITS     = 13;
  localparam int FRAC_BITS      = 8;
  localparam int POS_BITS       = COORD_BITS + FRAC_BITS;
  localparam int FACTOR_BITS    = 16;
  localparam int SIZE_BITS      = 14;
  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 16;

  typedef logic [COORD_BITS-1:0]    coord_t;
  typedef logic [POS_BITS-1:0]      pos_t;
  typedef logic [SIZE_BITS-1:0]     size_t;
  typedef logic [FACTOR_BITS-1:0]   factor_t;
  typedef logic [CFG_INDEX_BITS-1:0] cfg_index_t;
  typedef logic [CFG_DATA_BITS-1:0]  cfg_data_t;

  localparam pos_t POS_MAX = {{COORD_BITS{1'b1}}, {FRAC_BITS{1'b0}}};
  localparam int   SQ_THRESH_INT = (1 << (2 * FRAC_BITS)) / 100;
  localparam logic [2*POS_BITS:0] SQ_THRESH = (2*POS_BITS+1)'(SQ_THRESH_INT);
  localparam size_t SIZE_CAP = size_t'(1 << COORD_BITS);

  localparam factor_t FACTOR_RESET = factor_t'(29491);
  localparam size_t   WIDTH_RESET  = size_t'(1920);
  localparam size_t   HEIGHT_RESET = size_t'(1080);

  typedef enum logic [1:0] {
    KIND_MOVE    = 2'd0,
    KIND_TICK    = 2'd1,
    KIND_ENABLE  = 2'd2,
    KIND_DISABLE = 2'd3
  } kind_t;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_SMOOTHING_FACTOR = 2'd0,
    REG_SCREEN_WIDTH     = 2'd1,
    REG_SCREEN_HEIGHT    = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    kind_t  kind;
    coord_t event_x;
    coord_t event_y;
    logic   injected;
    coord_t cursor_x;
    coord_t cursor_y;
  } item_t;

  typedef struct packed {
    logic   set_cursor;
    coord_t new_x;
    coord_t new_y;
    logic   swallowed;
    logic   active;
  } result_t;

endpackage

// ----- rtl/pointer_exponential_smoother.sv -----
`timescale 1ns / 1ps
// Two-axis pointer smoother.
// Item channel (item_valid/item_ready/item): one beat per move event, tick,
// enable or disable. Result channel (result_valid/result_ready/result): exactly
// one beat for every item beat, in order.
// Config channel (cfg_valid/cfg_ready/cfg_index/cfg_data): always ready; index
// 0 smoothing factor (Q0.16), 1 screen width, 2 screen height. Write only
// while no result is outstanding.
// Throughput: one item per cycle while item_ready is high; the whole update
// of target and smoothed position is one combinational pass from the state
// registers into the state and result registers, so the next item sees the
// updated state.
// Stall: a result register plus a one-entry skid register; item_ready drops
// only while the skid register is full, so one more item is taken while a
// result waits. Nothing is dropped.
// Reset: synchronous rst clears positions to zero, disables smoothing, loads
// the default factor and screen size and empties the result stage.
module pointer_exponential_smoother (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_ready,
  input  pes_pkg::item_t      item,
  output logic                result_valid,
  input  logic                result_ready,
  output pes_pkg::result_t    result,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  pes_pkg::cfg_index_t cfg_index,
  input  pes_pkg::cfg_data_t  cfg_data
);
  import pes_pkg::*;

  factor_t smoothing_factor;
  size_t   screen_width;
  size_t   screen_height;

  pos_t target_x, target_y, smooth_x, smooth_y;
  logic enabled;

  pos_t target_x_next, target_y_next, smooth_x_next, smooth_y_next;
  logic enabled_next;

  result_t result_next;
  result_t skid;
  logic    skid_valid;
  logic    accept;

  logic signed [POS_BITS:0] diff_x, diff_y;
  pos_t                     mag_x, mag_y;
  logic [2*POS_BITS-1:0]    sq_x, sq_y;
  logic [2*POS_BITS:0]      sq_sum;
  logic                     far;
  pos_t                     step_x, step_y;
  pos_t                     move_x, move_y;
  pos_t                     lim_x, lim_y;

  function automatic pos_t screen_max(size_t s);
    coord_t last;
    if (s == '0) begin
      last = '0;
    end else if (s > SIZE_CAP) begin
      last = '1;
    end else begin
      last = COORD_BITS'(s - size_t'(1));
    end
    return {last, {FRAC_BITS{1'b0}}};
  endfunction

  function automatic pos_t move_target(pos_t t, coord_t e, coord_t c, pos_t lim);
    logic [COORD_BITS:0] d;
    logic [POS_BITS+1:0] sum;
    pos_t                r;
    d   = {1'b0, e} - {1'b0, c};
    sum = {2'b00, t} +
          {{(POS_BITS + 1 - COORD_BITS - FRAC_BITS){d[COORD_BITS]}}, d, {FRAC_BITS{1'b0}}};
    if (sum[POS_BITS+1]) begin
      r = '0;
    end else if (sum[POS_BITS:0] > {1'b0, lim}) begin
      r = lim;
    end else begin
      r = sum[POS_BITS-1:0];
    end
    return r;
  endfunction

  function automatic pos_t abs_diff(logic signed [POS_BITS:0] d);
    logic [POS_BITS:0] n;
    n = d[POS_BITS] ? -d : d;
    return n[POS_BITS-1:0];
  endfunction

  function automatic pos_t step_pos(pos_t sm, logic signed [POS_BITS:0] d, factor_t f);
    logic signed [POS_BITS+FACTOR_BITS+1:0] prod;
    logic signed [POS_BITS+1:0]             step;
    logic [POS_BITS+2:0]                    nxt;
    pos_t                                   r;
    prod = d * $signed({1'b0, f});
    prod = prod + $signed({{(POS_BITS+2){1'b0}}, 1'b1, {(FACTOR_BITS-1){1'b0}}});
    step = prod[POS_BITS+FACTOR_BITS+1:FACTOR_BITS];
    nxt  = {3'b000, sm} + {step[POS_BITS+1], step};
    if (nxt[POS_BITS+2]) begin
      r = '0;
    end else if (nxt[POS_BITS+1:0] > {2'b00, POS_MAX}) begin
      r = POS_MAX;
    end else begin
      r = nxt[POS_BITS-1:0];
    end
    return r;
  endfunction

  function automatic coord_t round_pos(pos_t p);
    pos_t r;
    r = p + pos_t'({1'b1, {(FRAC_BITS-1){1'b0}}});
    return r[POS_BITS-1:FRAC_BITS];
  endfunction

  assign item_ready = !skid_valid;
  assign accept     = item_valid && item_ready;
  assign cfg_ready  = 1'b1;

  assign lim_x  = screen_max(screen_width);
  assign lim_y  = screen_max(screen_height);
  assign move_x = move_target(target_x, item.event_x, item.cursor_x, lim_x);
  assign move_y = move_target(target_y, item.event_y, item.cursor_y, lim_y);

  assign diff_x = $signed({1'b0, target_x}) - $signed({1'b0, smooth_x});
  assign diff_y = $signed({1'b0, target_y}) - $signed({1'b0, smooth_y});
  assign mag_x  = abs_diff(diff_x);
  assign mag_y  = abs_diff(diff_y);
  assign sq_x   = mag_x * mag_x;
  assign sq_y   = mag_y * mag_y;
  assign sq_sum = {1'b0, sq_x} + {1'b0, sq_y};
  assign far    = sq_sum > SQ_THRESH;
  assign step_x = step_pos(smooth_x, diff_x, smoothing_factor);
  assign step_y = step_pos(smooth_y, diff_y, smoothing_factor);

  always_comb begin
    target_x_next          = target_x;
    target_y_next          = target_y;
    smooth_x_next          = smooth_x;
    smooth_y_next          = smooth_y;
    enabled_next           = enabled;
    result_next.set_cursor = 1'b0;
    result_next.swallowed  = 1'b0;
    unique case (item.kind)
      KIND_MOVE: begin
        if (enabled && !item.injected) begin
          result_next.swallowed = 1'b1;
          if ((item.event_x != item.cursor_x) || (item.event_y != item.cursor_y)) begin
            target_x_next = move_x;
            target_y_next = move_y;
          end
        end
      end
      KIND_TICK: begin
        if (!enabled) begin
          smooth_x_next = {item.cursor_x, {FRAC_BITS{1'b0}}};
          smooth_y_next = {item.cursor_y, {FRAC_BITS{1'b0}}};
          target_x_next = {item.cursor_x, {FRAC_BITS{1'b0}}};
          target_y_next = {item.cursor_y, {FRAC_BITS{1'b0}}};
        end else if (far) begin
          smooth_x_next          = step_x;
          smooth_y_next          = step_y;
          result_next.set_cursor = (round_pos(step_x) != item.cursor_x) ||
                                   (round_pos(step_y) != item.cursor_y);
        end else begin
          smooth_x_next = target_x;
          smooth_y_next = target_y;
        end
      end
      KIND_ENABLE: begin
        enabled_next  = 1'b1;
        smooth_x_next = {item.cursor_x, {FRAC_BITS{1'b0}}};
        smooth_y_next = {item.cursor_y, {FRAC_BITS{1'b0}}};
        target_x_next = {item.cursor_x, {FRAC_BITS{1'b0}}};
        target_y_next = {item.cursor_y, {FRAC_BITS{1'b0}}};
      end
      KIND_DISABLE: begin
        enabled_next = 1'b0;
      end
      default: begin
        enabled_next = enabled;
      end
    endcase
    result_next.new_x  = round_pos(smooth_x_next);
    result_next.new_y  = round_pos(smooth_y_next);
    result_next.active = enabled_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      smoothing_factor <= FACTOR_RESET;
      screen_width     <= WIDTH_RESET;
      screen_height    <= HEIGHT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_SMOOTHING_FACTOR: smoothing_factor <= cfg_data;
        REG_SCREEN_WIDTH:     screen_width     <= cfg_data[SIZE_BITS-1:0];
        REG_SCREEN_HEIGHT:    screen_height    <= cfg_data[SIZE_BITS-1:0];
        default:              smoothing_factor <= smoothing_factor;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      target_x <= '0;
      target_y <= '0;
      smooth_x <= '0;
      smooth_y <= '0;
      enabled  <= 1'b0;
    end else if (accept) begin
      target_x <= target_x_next;
      target_y <= target_y_next;
      smooth_x <= smooth_x_next;
      smooth_y <= smooth_y_next;
      enabled  <= enabled_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_valid   <= 1'b0;
    end else if (result_ready || !result_valid) begin
      result_valid <= skid_valid || accept;
      skid_valid   <= 1'b0;
    end else if (accept) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (result_ready || !result_valid) begin
      result <= skid_valid ? skid : result_next;
    end else if (accept) begin
      skid <= result_next;
    end
  end

  a_skid_behind_result: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> result_valid)
    else $error("skid entry held without a result in front");

  a_positions_in_range: assert property (@(posedge clk) disable iff (rst)
    (target_x <= POS_MAX) && (target_y <= POS_MAX) &&
    (smooth_x <= POS_MAX) && (smooth_y <= POS_MAX))
    else $error("position beyond coordinate range");

  a_target_on_screen: assert property (@(posedge clk) disable iff (rst)
    accept && item.kind == KIND_MOVE && enabled && !item.injected &&
    ((item.event_x != item.cursor_x) || (item.event_y != item.cursor_y)) |=>
    (target_x <= $past(lim_x)) && (target_y <= $past(lim_y)))
    else $error("target left the screen");

  a_enable_resyncs: assert property (@(posedge clk) disable iff (rst)
    accept && item.kind == KIND_ENABLE |=>
    enabled && smooth_x == target_x && smooth_y == target_y &&
    smooth_x[POS_BITS-1:FRAC_BITS] == $past(item.cursor_x))
    else $error("enable did not resync positions");

  a_disable_clears: assert property (@(posedge clk) disable iff (rst)
    accept && item.kind == KIND_DISABLE |=> !enabled && $stable(smooth_x))
    else $error("disable changed more than the enable flag");

endmodule
